@@ src/tbl_pkg.sv @@
// ----------------------------------------------------------------------------
// tbl_pkg
// shared types, constants and lookup functions of the tokenized basic lister
// ----------------------------------------------------------------------------
package tbl_pkg;

  // character and byte codes
  localparam logic [7:0] BYTE_LEAD = 8'hFF;
  localparam logic [7:0] BYTE_EOL  = 8'h00;
  localparam logic [7:0] TOKEN_MIN = 8'h80;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CLOSE  = 8'h5D;

  // prefix of an unknown token, left-justified
  localparam int unsigned    TOKPRE_LEN  = 9;
  localparam logic [71:0]    TOKPRE_TEXT = "[TOKEN:0x";
  localparam int unsigned    KW_MAX_LEN  = 8;
  localparam int unsigned    POS_W       = 4;

  // decimal conversion: q = (v * 52429) >> 19 equals v / 10 for 16-bit v
  localparam logic [31:0]    DIV10_MUL   = 32'd52429;
  localparam int unsigned    DIV10_SHIFT = 19;
  localparam int unsigned    NUM_W       = 16;
  localparam int unsigned    NUM_DIGITS  = 5;
  localparam int unsigned    NDIG_W      = 3;

  // command queue
  localparam int unsigned    FIFO_DEPTH  = 4;
  localparam int unsigned    FIFO_AW     = 2;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LINK_LO = 3'd1,
    PH_LINK_HI = 3'd2,
    PH_NUM_LO  = 3'd3,
    PH_NUM_HI  = 3'd4,
    PH_BODY    = 3'd5,
    PH_DONE    = 3'd6
  } ph_e;

  typedef enum logic [1:0] {
    CMD_NUMBER  = 2'd0,
    CMD_CHAR    = 2'd1,
    CMD_TOKEN   = 2'd2,
    CMD_NEWLINE = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    BK_IDLE   = 4'd0,
    BK_CONV   = 4'd1,
    BK_DIGIT  = 4'd2,
    BK_SPACE  = 4'd3,
    BK_KW     = 4'd4,
    BK_TOKPRE = 4'd5,
    BK_HEXHI  = 4'd6,
    BK_HEXLO  = 4'd7,
    BK_CLOSE  = 4'd8,
    BK_CHAR   = 4'd9,
    BK_NL     = 4'd10
  } bk_e;

  typedef struct packed {
    cmd_e              kind;
    logic [NUM_W-1:0]  value;   // line number, or the body byte in the low bits
    logic              add_nl;  // file ended here, close the line
  } tbl_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]      len;  // zero: no keyword for this code
    logic [8*KW_MAX_LEN-1:0] text; // left-justified, padded with spaces
  } kw_entry_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'h0, nib};
    else             c = 8'h37 + {4'h0, nib};
    return c;
  endfunction

  function automatic logic [7:0] tokpre_char(input logic [POS_W-1:0] pos);
    logic [71:0] sh;
    sh = TOKPRE_TEXT << {pos, 3'b000};
    return sh[71:64];
  endfunction

  function automatic logic [7:0] kw_char(input logic [8*KW_MAX_LEN-1:0] text,
                                         input logic [POS_W-1:0] pos);
    logic [8*KW_MAX_LEN-1:0] sh;
    sh = text << {pos, 3'b000};
    return sh[8*KW_MAX_LEN-1 -: 8];
  endfunction

  function automatic kw_entry_t kw_lookup(input logic [6:0] code);
    kw_entry_t e;
    unique case (code)
      7'h01: e = '{4'd3, "END     "};
      7'h02: e = '{4'd3, "FOR     "};
      7'h03: e = '{4'd4, "NEXT    "};
      7'h04: e = '{4'd4, "DATA    "};
      7'h05: e = '{4'd5, "INPUT   "};
      7'h06: e = '{4'd3, "DIM     "};
      7'h07: e = '{4'd4, "READ    "};
      7'h08: e = '{4'd3, "LET     "};
      7'h09: e = '{4'd4, "GOTO    "};
      7'h0A: e = '{4'd3, "RUN     "};
      7'h0B: e = '{4'd2, "IF      "};
      7'h0C: e = '{4'd7, "RESTORE "};
      7'h0D: e = '{4'd5, "GOSUB   "};
      7'h0E: e = '{4'd6, "RETURN  "};
      7'h0F: e = '{4'd3, "REM     "};
      7'h11: e = '{4'd5, "PRINT   "};
      7'h12: e = '{4'd2, "ON      "};
      7'h16: e = '{4'd3, "DEF     "};
      7'h17: e = '{4'd4, "POKE    "};
      7'h18: e = '{4'd6, "PRINT#  "};
      7'h19: e = '{4'd6, "SECURE  "};
      7'h1A: e = '{4'd3, "CLS     "};
      7'h1B: e = '{4'd5, "WIDTH   "};
      7'h1C: e = '{4'd4, "ELSE    "};
      7'h1D: e = '{4'd4, "TRON    "};
      7'h1E: e = '{4'd5, "TROFF   "};
      7'h1F: e = '{4'd4, "SWAP    "};
      7'h20: e = '{4'd5, "ERASE   "};
      7'h21: e = '{4'd4, "EDIT    "};
      7'h22: e = '{4'd5, "ERROR   "};
      7'h23: e = '{4'd6, "RESUME  "};
      7'h24: e = '{4'd4, "PLAY    "};
      7'h25: e = '{4'd8, "ON/ERROR"};
      7'h26: e = '{4'd4, "LIST    "};
      7'h27: e = '{4'd3, "NEW     "};
      7'h28: e = '{4'd6, "ON/KEY  "};
      7'h29: e = '{4'd7, "ON/PLAY "};
      7'h2A: e = '{4'd8, "ON/TIMER"};
      7'h2B: e = '{4'd6, "OPTION  "};
      7'h2C: e = '{4'd7, "ENVIRON "};
      7'h2D: e = '{4'd6, "SYSTEM  "};
      7'h2E: e = '{4'd3, "KEY     "};
      7'h2F: e = '{4'd5, "SHELL   "};
      7'h30: e = '{4'd5, "CLOSE   "};
      7'h31: e = '{4'd4, "LOAD    "};
      7'h32: e = '{4'd5, "MERGE   "};
      7'h33: e = '{4'd4, "SAVE    "};
      7'h34: e = '{4'd5, "COLOR   "};
      7'h37: e = '{4'd4, "OPEN    "};
      7'h38: e = '{4'd5, "FIELD   "};
      7'h39: e = '{4'd3, "GET     "};
      7'h3A: e = '{4'd3, "PUT     "};
      7'h3B: e = '{4'd4, "SEEK    "};
      7'h3C: e = '{4'd5, "FILES   "};
      7'h3D: e = '{4'd4, "KILL    "};
      7'h3E: e = '{4'd5, "CHDIR   "};
      7'h3F: e = '{4'd5, "MKDIR   "};
      7'h40: e = '{4'd5, "RMDIR   "};
      7'h41: e = '{4'd4, "NAME    "};
      7'h42: e = '{4'd4, "LINE    "};
      7'h43: e = '{4'd6, "CIRCLE  "};
      7'h44: e = '{4'd4, "PSET    "};
      7'h45: e = '{4'd6, "PRESET  "};
      7'h46: e = '{4'd6, "SCREEN  "};
      7'h47: e = '{4'd5, "PAINT   "};
      7'h48: e = '{4'd5, "SOUND   "};
      7'h4C: e = '{4'd5, "USING   "};
      7'h4D: e = '{4'd4, "THEN    "};
      7'h4E: e = '{4'd2, "TO      "};
      7'h4F: e = '{4'd4, "STEP    "};
      7'h50: e = '{4'd3, "DIR     "};
      7'h51: e = '{4'd7, "SETATTR "};
      7'h52: e = '{4'd4, "LOCK    "};
      7'h53: e = '{4'd6, "UNLOCK  "};
      default: e = '{4'd0, 64'h0};
    endcase
    return e;
  endfunction

endpackage

@@ src/tbl_ifs.sv @@
// ----------------------------------------------------------------------------
// tbl stream interfaces
// valid/ready channels for file bytes in and listing characters out
// ----------------------------------------------------------------------------
interface tbl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface tbl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       run_last;

  modport source (output valid, output text_char, output run_last, input ready);
  modport sink   (input valid, input text_char, input run_last, output ready);
endinterface

@@ src/tbl_fifo.sv @@
// ----------------------------------------------------------------------------
// tbl_fifo
// small command queue between the byte parser and the character generator
// ----------------------------------------------------------------------------
module tbl_fifo
  import tbl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tbl_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output tbl_cmd_t head_o,
  output logic     empty_o
);

  tbl_cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]       cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (FIFO_AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (FIFO_AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/tbl_front.sv @@
// ----------------------------------------------------------------------------
// tbl_front
// parses file bytes into line number and body commands
// ----------------------------------------------------------------------------
module tbl_front
  import tbl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  logic [7:0] file_byte_i,
  input  logic     end_of_file_i,
  input  logic     full_i,
  output logic     push_o,
  output tbl_cmd_t cmd_o
);

  ph_e        ph_q, ph_d;
  logic [7:0] held_q, held_d;
  logic       acc;

  assign ready_o = !full_i;
  assign acc     = valid_i && ready_o;

  // next phase
  always_comb begin
    ph_d = ph_q;
    if (acc) begin
      if (end_of_file_i) begin
        ph_d = PH_START;
      end else begin
        unique case (ph_q)
          PH_START:   ph_d = (file_byte_i == BYTE_LEAD) ? PH_LINK_LO : PH_LINK_HI;
          PH_LINK_LO: ph_d = PH_LINK_HI;
          PH_LINK_HI: ph_d = (held_q == 8'h00 && file_byte_i == 8'h00) ? PH_DONE
                                                                       : PH_NUM_LO;
          PH_NUM_LO:  ph_d = PH_NUM_HI;
          PH_NUM_HI:  ph_d = PH_BODY;
          PH_BODY:    ph_d = (file_byte_i == BYTE_EOL) ? PH_LINK_LO : PH_BODY;
          default:    ph_d = ph_q;
        endcase
      end
    end
  end

  // held byte and command output
  always_comb begin
    held_d       = held_q;
    push_o       = 1'b0;
    cmd_o.kind   = CMD_CHAR;
    cmd_o.value  = {8'h00, file_byte_i};
    cmd_o.add_nl = end_of_file_i;
    if (acc) begin
      unique case (ph_q)
        PH_START: begin
          if (file_byte_i != BYTE_LEAD) held_d = file_byte_i;
        end
        PH_LINK_LO, PH_NUM_LO: begin
          held_d = file_byte_i;
        end
        PH_NUM_HI: begin
          push_o      = 1'b1;
          cmd_o.kind  = CMD_NUMBER;
          cmd_o.value = {file_byte_i, held_q};
        end
        PH_BODY: begin
          push_o = 1'b1;
          if (file_byte_i == BYTE_EOL) begin
            cmd_o.kind   = CMD_NEWLINE;
            cmd_o.add_nl = 1'b0;
          end else if (file_byte_i >= TOKEN_MIN) begin
            cmd_o.kind = CMD_TOKEN;
          end
        end
        default: ;
      endcase
      if (end_of_file_i) held_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_START;
      held_q <= 8'h00;
    end else begin
      ph_q   <= ph_d;
      held_q <= held_d;
    end
  end

endmodule

@@ src/tbl_back.sv @@
// ----------------------------------------------------------------------------
// tbl_back
// expands queued commands into listing characters, at most one per cycle, held while the output stalls
// ----------------------------------------------------------------------------
module tbl_back
  import tbl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  tbl_cmd_t   head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] text_char_o,
  output logic       run_last_o
);

  bk_e              st_q, st_d;
  logic             nl_q;
  logic [7:0]       byte_q;
  logic [NUM_W-1:0] val_q;
  logic [3:0]       dig_q [NUM_DIGITS];
  logic [NDIG_W-1:0] ndig_q;
  logic [POS_W-1:0] pos_q;
  kw_entry_t        kw_q;
  kw_entry_t        kw_head;

  logic             out_vld_q;
  logic [7:0]       out_char_q;
  logic             out_last_q;

  logic             adv, go;
  logic             emit_vld, emit_last;
  logic [7:0]       emit_char;

  logic [31:0]      prod;
  logic [NUM_W-1:0] quo, rem;

  assign kw_head = kw_lookup(head_i.value[6:0]);

  // divide by ten through the reciprocal
  assign prod = {16'h0000, val_q} * DIV10_MUL;
  assign quo  = NUM_W'(prod >> DIV10_SHIFT);
  assign rem  = val_q - ({quo[NUM_W-4:0], 3'b000} + {quo[NUM_W-2:0], 1'b0});

  assign adv = !out_vld_q || out_ready_i;
  assign go  = !emit_vld || adv;

  // character output per state
  always_comb begin
    emit_vld  = 1'b1;
    emit_char = CH_NL;
    emit_last = !nl_q;
    pop_o     = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        emit_vld = 1'b0;
        pop_o    = !empty_i;
      end
      BK_CONV:   emit_vld = 1'b0;
      BK_DIGIT: begin
        emit_char = CH_ZERO + {4'h0, dig_q[0]};
        emit_last = 1'b0;
      end
      BK_SPACE:  emit_char = CH_SPACE;
      BK_KW: begin
        emit_char = kw_char(kw_q.text, pos_q);
        emit_last = (pos_q == kw_q.len - POS_W'(1)) && !nl_q;
      end
      BK_TOKPRE: begin
        emit_char = tokpre_char(pos_q);
        emit_last = 1'b0;
      end
      BK_HEXHI: begin
        emit_char = hex_char(byte_q[7:4]);
        emit_last = 1'b0;
      end
      BK_HEXLO: begin
        emit_char = hex_char(byte_q[3:0]);
        emit_last = 1'b0;
      end
      BK_CLOSE:  emit_char = CH_CLOSE;
      BK_CHAR:   emit_char = byte_q;
      BK_NL:     emit_last = 1'b1;
      default:   emit_vld = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    if (go) begin
      unique case (st_q)
        BK_IDLE: begin
          if (!empty_i) begin
            unique case (head_i.kind)
              CMD_NUMBER:  st_d = BK_CONV;
              CMD_CHAR:    st_d = BK_CHAR;
              CMD_TOKEN:   st_d = (kw_head.len != '0) ? BK_KW : BK_TOKPRE;
              CMD_NEWLINE: st_d = BK_NL;
              default:     st_d = BK_IDLE;
            endcase
          end
        end
        BK_CONV:   if (quo == '0) st_d = BK_DIGIT;
        BK_DIGIT:  if (ndig_q == NDIG_W'(1)) st_d = BK_SPACE;
        BK_KW:     if (pos_q == kw_q.len - POS_W'(1)) st_d = nl_q ? BK_NL : BK_IDLE;
        BK_TOKPRE: if (pos_q == POS_W'(TOKPRE_LEN - 1)) st_d = BK_HEXHI;
        BK_HEXHI:  st_d = BK_HEXLO;
        BK_HEXLO:  st_d = BK_CLOSE;
        BK_SPACE, BK_CLOSE, BK_CHAR: st_d = nl_q ? BK_NL : BK_IDLE;
        BK_NL:     st_d = BK_IDLE;
        default:   st_d = BK_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (st_q == BK_IDLE && !empty_i) begin
      nl_q   <= head_i.add_nl;
      byte_q <= head_i.value[7:0];
      val_q  <= head_i.value;
      kw_q   <= kw_head;
      pos_q  <= '0;
      ndig_q <= '0;
    end else if (go) begin
      unique case (st_q)
        BK_CONV: begin
          val_q    <= quo;
          ndig_q   <= ndig_q + NDIG_W'(1);
          dig_q[0] <= rem[3:0];
          for (int i = 1; i < NUM_DIGITS; i++) dig_q[i] <= dig_q[i-1];
        end
        BK_DIGIT: begin
          ndig_q <= ndig_q - NDIG_W'(1);
          for (int i = 0; i < NUM_DIGITS - 1; i++) dig_q[i] <= dig_q[i+1];
        end
        BK_KW: pos_q <= pos_q + POS_W'(1);
        BK_TOKPRE: begin
          pos_q <= pos_q + POS_W'(1);
        end
        default: ;
      endcase
    end
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= BK_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (adv) out_vld_q <= emit_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit_vld) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign text_char_o = out_char_q;
  assign run_last_o  = out_last_q;

endmodule

@@ src/tokenized_basic_lister_core.sv @@
// ----------------------------------------------------------------------------
// tokenized_basic_lister_core
// turns a tokenized basic program, byte by byte, into its text listing
// ----------------------------------------------------------------------------
// file_i takes one word per file byte with end_of_file on the last byte of a
// file; text_o gives one word per listing character, run_last set on the last
// character that one file byte causes. header bytes that print nothing give
// no words at all.
// the parser (front) classifies each byte in the cycle it is taken and drops
// a command into a four-entry queue; the generator (back) pops a command in
// its dispatch state, converts a line number into decimal digits (reciprocal
// multiply), and gives at most one character per cycle through its output
// register while text_o does not stall. the generator takes the next command
// only after registering the last character of the current one, while the
// parser keeps taking file bytes, header bytes one per cycle, as long as the
// queue has room. reset puts the parser at the start of a file and empties
// queue and output. a stall on text_o holds the output register; the queue
// then fills and file_i.ready drops only when all four entries are taken.
// ----------------------------------------------------------------------------
module tokenized_basic_lister_core
  import tbl_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  tbl_in_if.sink    file_i,
  tbl_out_if.source text_o
);

  // queue handshake between parser and generator
  logic     q_push, q_full, q_pop, q_empty;
  tbl_cmd_t q_in, q_head;

  tbl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (file_i.valid),
    .ready_o       (file_i.ready),
    .file_byte_i   (file_i.file_byte),
    .end_of_file_i (file_i.end_of_file),
    .full_i        (q_full),
    .push_o        (q_push),
    .cmd_o         (q_in)
  );

  tbl_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  // generator drives the output word register directly
  tbl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (text_o.valid),
    .out_ready_i (text_o.ready),
    .text_char_o (text_o.text_char),
    .run_last_o  (text_o.run_last)
  );

endmodule

@@ tb/tb_tokenized_basic_lister_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tokenized_basic_lister_core
// self-checking bench: feeds tokenized programs byte by byte, predicts the
// listing characters of every byte and compares each text word on arrival
// ----------------------------------------------------------------------------
module tb_tokenized_basic_lister_core;
  import tbl_pkg::*;

  // one expected listing character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } listing_char_t;

  // one directed row: file byte, end flag, and the listing typed in by hand
  // when typed is set (right-justified text, zero bytes are padding)
  typedef struct packed {
    logic [7:0]   b;
    logic         eof;
    logic         typed;
    logic [103:0] text;
  } dir_row_t;

  localparam logic [103:0] NO_TEXT     = '0;
  localparam int           DIR_ROWS    = 26;
  localparam int           ITEM_TARGET = 460;
  localparam int           HOLD_CYCLES = 300;
  localparam int           DRAIN_WAIT  = 30;
  localparam int           PRINT_MAX   = 20;

  logic clk_i;
  logic rst_ni;

  tbl_in_if  file_if ();
  tbl_out_if text_if ();

  tokenized_basic_lister_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .file_i (file_if),
    .text_o (text_if)
  );

  // directed program pieces: edge values, every kind of byte, odd endings
  dir_row_t dir_rows [DIR_ROWS] = '{
    // lead byte, nonzero link, line number at its maximum
    '{8'hFF, 1'b0, 1'b1, NO_TEXT},
    '{8'h10, 1'b0, 1'b1, NO_TEXT},
    '{8'h00, 1'b0, 1'b1, NO_TEXT},
    '{8'hFF, 1'b0, 1'b1, NO_TEXT},
    '{8'hFF, 1'b0, 1'b1, "65535 "},
    // lowest token has no keyword, first and last keywords, top byte
    '{8'h80, 1'b0, 1'b1, "[TOKEN:0x80]"},
    '{8'h81, 1'b0, 1'b1, "END"},
    '{8'hD3, 1'b0, 1'b1, "UNLOCK"},
    '{8'hFF, 1'b0, 1'b1, "[TOKEN:0xFF]"},
    '{8'h7F, 1'b0, 1'b0, NO_TEXT},
    '{8'h00, 1'b0, 1'b1, "\n"},
    // next line: line number zero, file ends on its high byte
    '{8'h00, 1'b0, 1'b1, NO_TEXT},
    '{8'h01, 1'b0, 1'b1, NO_TEXT},
    '{8'h00, 1'b0, 1'b1, NO_TEXT},
    '{8'h00, 1'b1, 1'b1, "0 \n"},
    // no lead byte, file ends inside the body
    '{8'h05, 1'b0, 1'b1, NO_TEXT},
    '{8'h00, 1'b0, 1'b1, NO_TEXT},
    '{8'h0A, 1'b0, 1'b1, NO_TEXT},
    '{8'h00, 1'b0, 1'b1, "10 "},
    '{8'h41, 1'b1, 1'b1, "A\n"},
    // zero link stops decoding, the rest is ignored
    '{8'hFF, 1'b0, 1'b1, NO_TEXT},
    '{8'h00, 1'b0, 1'b1, NO_TEXT},
    '{8'h00, 1'b0, 1'b1, NO_TEXT},
    '{8'hAA, 1'b0, 1'b1, NO_TEXT},
    '{8'h00, 1'b1, 1'b1, NO_TEXT},
    // one-byte file that ends in the link
    '{8'h00, 1'b1, 1'b1, NO_TEXT}
  };

  // ---------------------------------------------------------------------------
  // listing predictor
  // ---------------------------------------------------------------------------
  ph_e           parse_phase;
  logic [7:0]    pending_low;    // low byte of link or line number
  listing_char_t step_chars[$];  // characters of the byte just decoded
  listing_char_t listing_q[$];   // characters still to arrive on text_o

  function automatic string keyword_text(input logic [6:0] code);
    string kw;
    kw = "";
    case (code)
      7'h01: kw = "END";      7'h02: kw = "FOR";      7'h03: kw = "NEXT";
      7'h04: kw = "DATA";     7'h05: kw = "INPUT";    7'h06: kw = "DIM";
      7'h07: kw = "READ";     7'h08: kw = "LET";      7'h09: kw = "GOTO";
      7'h0A: kw = "RUN";      7'h0B: kw = "IF";       7'h0C: kw = "RESTORE";
      7'h0D: kw = "GOSUB";    7'h0E: kw = "RETURN";   7'h0F: kw = "REM";
      7'h11: kw = "PRINT";    7'h12: kw = "ON";       7'h16: kw = "DEF";
      7'h17: kw = "POKE";     7'h18: kw = "PRINT#";   7'h19: kw = "SECURE";
      7'h1A: kw = "CLS";      7'h1B: kw = "WIDTH";    7'h1C: kw = "ELSE";
      7'h1D: kw = "TRON";     7'h1E: kw = "TROFF";    7'h1F: kw = "SWAP";
      7'h20: kw = "ERASE";    7'h21: kw = "EDIT";     7'h22: kw = "ERROR";
      7'h23: kw = "RESUME";   7'h24: kw = "PLAY";     7'h25: kw = "ON/ERROR";
      7'h26: kw = "LIST";     7'h27: kw = "NEW";      7'h28: kw = "ON/KEY";
      7'h29: kw = "ON/PLAY";  7'h2A: kw = "ON/TIMER"; 7'h2B: kw = "OPTION";
      7'h2C: kw = "ENVIRON";  7'h2D: kw = "SYSTEM";   7'h2E: kw = "KEY";
      7'h2F: kw = "SHELL";    7'h30: kw = "CLOSE";    7'h31: kw = "LOAD";
      7'h32: kw = "MERGE";    7'h33: kw = "SAVE";     7'h34: kw = "COLOR";
      7'h37: kw = "OPEN";     7'h38: kw = "FIELD";    7'h39: kw = "GET";
      7'h3A: kw = "PUT";      7'h3B: kw = "SEEK";     7'h3C: kw = "FILES";
      7'h3D: kw = "KILL";     7'h3E: kw = "CHDIR";    7'h3F: kw = "MKDIR";
      7'h40: kw = "RMDIR";    7'h41: kw = "NAME";     7'h42: kw = "LINE";
      7'h43: kw = "CIRCLE";   7'h44: kw = "PSET";     7'h45: kw = "PRESET";
      7'h46: kw = "SCREEN";   7'h47: kw = "PAINT";    7'h48: kw = "SOUND";
      7'h4C: kw = "USING";    7'h4D: kw = "THEN";     7'h4E: kw = "TO";
      7'h4F: kw = "STEP";     7'h50: kw = "DIR";      7'h51: kw = "SETATTR";
      7'h52: kw = "LOCK";     7'h53: kw = "UNLOCK";
      default: kw = "";
    endcase
    return kw;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + 8'(nib);
    else             c = 8'h41 + 8'(nib) - 8'd10;
    return c;
  endfunction

  function automatic void put_char(input logic [7:0] c);
    step_chars.push_back('{c, 1'b0});
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  // keyword, or the bracketed hex form when the code has none
  function automatic void put_token(input logic [7:0] b);
    string kw;
    kw = keyword_text(b[6:0]);
    if (kw.len() != 0) begin
      put_text(kw);
    end else begin
      put_text("[TOKEN:0x");
      put_char(hex_digit(b[7:4]));
      put_char(hex_digit(b[3:0]));
      put_char(CH_CLOSE);
    end
  endfunction

  // decode one file byte into step_chars and advance the parse state
  function automatic void list_byte(input logic [7:0] b, input logic eof);
    step_chars.delete();
    case (parse_phase)
      PH_START: begin
        // without a lead byte the first byte is already the link low byte
        if (b == BYTE_LEAD) begin
          parse_phase = PH_LINK_LO;
        end else begin
          pending_low = b;
          parse_phase = PH_LINK_HI;
        end
      end
      PH_LINK_LO: begin
        pending_low = b;
        parse_phase = PH_LINK_HI;
      end
      PH_LINK_HI: begin
        if (pending_low == 8'h00 && b == 8'h00) parse_phase = PH_DONE;
        else                                    parse_phase = PH_NUM_LO;
      end
      PH_NUM_LO: begin
        pending_low = b;
        parse_phase = PH_NUM_HI;
      end
      PH_NUM_HI: begin
        put_text($sformatf("%0d ", {b, pending_low}));
        parse_phase = PH_BODY;
        if (eof) put_char(CH_NL);
      end
      PH_BODY: begin
        if (b == BYTE_EOL) begin
          put_char(CH_NL);
          parse_phase = PH_LINK_LO;
        end else begin
          if (b >= TOKEN_MIN) put_token(b);
          else                put_char(b);
          if (eof) put_char(CH_NL);
        end
      end
      default: begin
        // after a zero link nothing prints until the file ends
      end
    endcase
    if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
    if (eof) begin
      parse_phase = PH_START;
      pending_low = 8'h00;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  int   mismatches   = 0;
  int   chars_seen   = 0;
  int   bytes_sent   = 0;
  int   live_items   = 0;   // bytes not swallowed after a zero link
  int   files_sent   = 0;
  logic in_calm      = 1'b0;
  logic out_calm     = 1'b0;
  logic hold_go      = 1'b0;
  logic out_hold     = 1'b0;
  logic [7:0] file_q[$];

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= PRINT_MAX) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // worst case is far below this: ~600 bytes, 13 words each, with stalls
  initial begin
    #2_000_000;
    $display("timeout: listing did not drain, %0d words outstanding", listing_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // long receiver hold-off: the four-entry queue fills and file_i stalls
  // ---------------------------------------------------------------------------
  initial begin
    wait (hold_go);
    out_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    out_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // text_o sink: random stall per word, checks every accepted word
  // ---------------------------------------------------------------------------
  initial begin
    int            stall_left;
    int            words;
    listing_char_t want;
    stall_left    = 0;
    words         = 0;
    text_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (out_hold) begin
        text_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        text_if.ready <= 1'b0;
        stall_left--;
      end else begin
        text_if.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (text_if.valid && text_if.ready) begin
        chars_seen++;
        if (listing_q.size() == 0) begin
          report($sformatf("unexpected word 0x%02h run_last %0b",
                           text_if.text_char, text_if.run_last));
        end else begin
          want = listing_q.pop_front();
          if (text_if.text_char !== want.ch)
            report($sformatf("text_char 0x%02h, expected 0x%02h",
                             text_if.text_char, want.ch));
          if (text_if.run_last !== want.last)
            report($sformatf("run_last %0b, expected %0b on char 0x%02h",
                             text_if.run_last, want.last, want.ch));
        end
        // stretches of back-to-back acceptance alternate with random stalls
        if (words % 32 == 0) out_calm = ($urandom_range(0, 3) == 0);
        words++;
        stall_left = out_calm ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // file_i driver: one word per file byte, expectation built on acceptance
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eof, input logic typed,
                           input logic [103:0] text);
    int         gap;
    logic [7:0] c;
    if (bytes_sent % 32 == 0) in_calm = ($urandom_range(0, 3) == 0);
    gap = in_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      file_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    file_if.valid       <= 1'b1;
    file_if.file_byte   <= b;
    file_if.end_of_file <= eof;
    do @(posedge clk_i); while (!file_if.ready);
    bytes_sent++;
    if (parse_phase != PH_DONE) live_items++;
    if (eof) files_sent++;
    list_byte(b, eof);
    // hand-typed rows override the prediction for this byte
    if (typed) begin
      step_chars.delete();
      for (int i = 12; i >= 0; i--) begin
        c = text[8*i +: 8];
        if (c != 8'h00) step_chars.push_back('{c, 1'b0});
      end
      if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
    end
    foreach (step_chars[i]) listing_q.push_back(step_chars[i]);
    if (!hold_go && live_items >= 200) hold_go = 1'b1;
    @(negedge clk_i);
  endtask

  // well-formed program with random content and a random ending
  task automatic build_program();
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] num;
    int          cut;
    file_q.delete();
    if ($urandom_range(0, 9) != 0) file_q.push_back(BYTE_LEAD);
    repeat ($urandom_range(1, 4)) begin
      lo = 8'($urandom);
      hi = 8'($urandom);
      if (lo == 8'h00 && hi == 8'h00) lo = 8'h01;
      file_q.push_back(lo);
      file_q.push_back(hi);
      case ($urandom_range(0, 5))
        0:       num = 16'h0000;
        1:       num = 16'hFFFF;
        2, 3:    num = 16'($urandom_range(1, 999));
        default: num = 16'($urandom);
      endcase
      file_q.push_back(num[7:0]);
      file_q.push_back(num[15:8]);
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 1) == 0) file_q.push_back(8'($urandom_range(1, 127)));
        else                           file_q.push_back(8'($urandom_range(128, 255)));
      end
      file_q.push_back(BYTE_EOL);
    end
    case ($urandom_range(0, 2))
      0: begin
        // zero link, then trailing bytes that must print nothing
        file_q.push_back(8'h00);
        file_q.push_back(8'h00);
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
      end
      1: begin
        // file cut short anywhere
        cut = $urandom_range(1, file_q.size());
        while (file_q.size() > cut) void'(file_q.pop_back());
      end
      default: begin
        // ends right after a line's terminating zero
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int guard;
    file_if.valid       = 1'b0;
    file_if.file_byte   = 8'h00;
    file_if.end_of_file = 1'b0;
    parse_phase         = PH_START;
    pending_low         = 8'h00;
    rst_ni              = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++)
      send_byte(dir_rows[r].b, dir_rows[r].eof, dir_rows[r].typed, dir_rows[r].text);

    // mostly well-formed programs, some raw noise files
    while (live_items < ITEM_TARGET) begin
      if ($urandom_range(0, 6) == 0) begin
        file_q.delete();
        repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
      end else begin
        build_program();
      end
      for (int i = 0; i < file_q.size(); i++)
        send_byte(file_q[i], (i == file_q.size() - 1), 1'b0, NO_TEXT);
    end
    file_if.valid <= 1'b0;

    // drain, then give the back end time to show any stray word
    while (listing_q.size() != 0) @(posedge clk_i);
    guard = 0;
    while (guard < DRAIN_WAIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (listing_q.size() != 0)
      report($sformatf("%0d listing characters never arrived", listing_q.size()));

    $display("covered %0d files, %0d file bytes (%0d decoded), %0d listing characters",
             files_sent, bytes_sent, live_items, chars_seen);
    $display("including a %0d-cycle receiver hold-off, %0d mismatches",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
